>>> design/vacg_pkg.sv
package vacg_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 19;

    // Register field widths
    localparam int FRAME_LENGTH_W   = 10;
    localparam int FRAME_LIMIT_W    = 10;
    localparam int STORE_CAPACITY_W = 19;
    localparam int STOP_MIN_W       = 14;
    localparam int SPEECH_MIN_W     = 14;

    // Payload widths
    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 16;
    localparam int SQ_W         = 31;
    localparam int COUNT_W      = 19;
    localparam int FRAME_CNT_W  = 10;
    localparam int VOICE_RUN_W  = 2;
    localparam int QUIET_RUN_W  = 6;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 48;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LENGTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_LIMIT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STORE_CAPACITY = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STOP_MIN       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPEECH_MIN     = 3'd4;

    // Reset values of the registers
    localparam logic [FRAME_LENGTH_W-1:0]   RST_FRAME_LENGTH   = 10'd320;
    localparam logic [FRAME_LIMIT_W-1:0]    RST_FRAME_LIMIT    = 10'd250;
    localparam logic [STORE_CAPACITY_W-1:0] RST_STORE_CAPACITY = 19'd80000;
    localparam logic [STOP_MIN_W-1:0]       RST_STOP_MIN       = 14'd8000;
    localparam logic [SPEECH_MIN_W-1:0]     RST_SPEECH_MIN     = 14'd4000;

    localparam int DEFAULT_MAX_FRAME_LEN = 512;

    // Detector constants
    localparam logic [FRAME_CNT_W-1:0] NOISE_FRAMES    = 10'd25;
    localparam logic [MAG_W-1:0]       FLOOR_KNEE      = 16'd300;
    localparam logic [17:0]            FLOOR_MIN_THR   = 18'd900;
    localparam logic [19:0]            ENERGY_LIMIT    = 20'd550001;
    localparam logic [QUIET_RUN_W-1:0] QUIET_STOP      = 6'd35;
    localparam logic [QUIET_RUN_W-1:0] QUIET_MAX       = 6'd63;
    localparam logic [VOICE_RUN_W-1:0] VOICE_TRIGGER   = 2'd3;
    localparam logic [FRAME_CNT_W-1:0] FRAME_CNT_MAX   = 10'd1023;

    // Static configuration handed to the core
    typedef struct packed {
        logic [FRAME_LIMIT_W-1:0]    frame_limit;
        logic [STORE_CAPACITY_W-1:0] store_capacity;
        logic [STOP_MIN_W-1:0]       stop_min;
        logic [SPEECH_MIN_W-1:0]     speech_min;
    } cfg_t;

endpackage

>>> design/voice_activity_capture_gate_core.sv
// Channel  Dir  Handshake            Payload
// s_       in   s_tvalid/s_tready    tdata: sample_value; tlast: source_end
// m_       out  m_tvalid/m_tready    tdata: index and status; tlast: frame_done;
//                                    tuser: keep_sample
// cfg_     in   cfg_wr_en            cfg_addr, cfg_wdata (no read-back)
//
// One sample per clock while the output is not stalled. The magnitude and
// square are registered at input, then the frame accumulate, voiced decision
// and capture control close the state feedback and load the result register.
// Reset is synchronous on aresetn and restores register defaults.
// A stalled result holds in the output register; one more item is taken
// into the input register while it waits.
module voice_activity_capture_gate_core #(
    parameter int MAX_FRAME_LEN = vacg_pkg::DEFAULT_MAX_FRAME_LEN
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample_value [15:0]
    input  logic [vacg_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            s_tlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // store_index [18:0], frame_voiced [19], gate_open [20], capture_over [21],
    // speech_found [22], captured_count [41:23], zero [47:42]
    output logic [vacg_pkg::M_TDATA_W-1:0]  m_tdata,
    // keep_sample [0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_wr_en,
    input  logic [vacg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vacg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LEN_W    = $clog2(MAX_FRAME_LEN + 1);
    localparam int SIF_W    = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;
    localparam int THR_W    = 20 + LEN_W;
    localparam int ENERGY_W = 30 + LEN_W;
    localparam int SUM_W    = ((LEN_W > vacg_pkg::COUNT_W) ? LEN_W : vacg_pkg::COUNT_W) + 1;
    localparam int CW       = vacg_pkg::COUNT_W;

    vacg_pkg::cfg_t    cfg;
    logic [LEN_W-1:0]  eff_len;
    logic [THR_W-1:0]  energy_thr;

    vacg_cfg_regs #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .LEN_W         (LEN_W),
        .THR_W         (THR_W)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg),
        .eff_len    (eff_len),
        .energy_thr (energy_thr)
    );

    // ---------------- input stage ----------------
    logic                         in_valid_reg;
    logic [vacg_pkg::MAG_W-1:0]   mag_reg;
    logic [vacg_pkg::SQ_W-1:0]    sq_reg;
    logic                         end_reg;
    logic [vacg_pkg::MAG_W-1:0]   mag_in;
    logic [31:0]                  sq_full;
    logic                         advance;

    assign mag_in  = s_tdata[vacg_pkg::SAMPLE_W-1] ? (~s_tdata + 16'd1) : s_tdata;
    assign sq_full = {16'b0, mag_in} * {16'b0, mag_in};

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            mag_reg <= mag_in;
            sq_reg  <= sq_full[vacg_pkg::SQ_W-1:0];
            end_reg <= s_tlast;
        end
    end

    // ---------------- frame and capture state ----------------
    logic [SIF_W-1:0]                    sif_reg, sif_next;
    logic [vacg_pkg::MAG_W-1:0]          peak_reg, peak_next;
    logic [ENERGY_W-1:0]                 energy_reg, energy_next;
    logic [vacg_pkg::FRAME_CNT_W-1:0]    fcount_reg, fcount_next;
    logic [vacg_pkg::MAG_W-1:0]          floor_reg, floor_next;
    logic [vacg_pkg::VOICE_RUN_W-1:0]    vrun_reg, vrun_next;
    logic [vacg_pkg::QUIET_RUN_W-1:0]    qrun_reg, qrun_next;
    logic                                trig_reg, trig_next;
    logic                                fin_reg, fin_next;
    logic [CW-1:0]                       stored_reg, stored_next;

    // Per-sample arithmetic
    logic [vacg_pkg::MAG_W-1:0]   peak_new;
    logic [ENERGY_W-1:0]          energy_new;
    logic                         frame_end;
    logic                         limit_now;
    logic                         limit_after;
    logic [19:0]                  floor_sum;
    logic [vacg_pkg::MAG_W-1:0]   floor_avg;
    logic [17:0]                  floor_thr;
    logic [CW-1:0]                stored_add;
    logic [CW-1:0]                index_now;

    assign peak_new   = (mag_reg > peak_reg) ? mag_reg : peak_reg;
    assign energy_new = energy_reg + ENERGY_W'(sq_reg);
    assign frame_end  = ((LEN_W + 1)'(sif_reg) + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(eff_len);

    assign limit_now = (fcount_reg >= cfg.frame_limit) ||
                       (SUM_W'(stored_reg) + SUM_W'(eff_len) > SUM_W'(cfg.store_capacity));
    assign limit_after = (fcount_next >= cfg.frame_limit) ||
                         (SUM_W'(stored_next) + SUM_W'(eff_len) > SUM_W'(cfg.store_capacity));

    // 7/8 running average of frame peaks
    assign floor_sum = ({4'b0, floor_reg} << 3) - {4'b0, floor_reg} + {4'b0, peak_new};
    assign floor_avg = floor_sum[18:3];
    assign floor_thr = (floor_next > vacg_pkg::FLOOR_KNEE) ?
                       (18'(floor_next) + {1'b0, floor_next, 1'b0}) : vacg_pkg::FLOOR_MIN_THR;

    assign stored_add = CW'(SUM_W'(stored_reg) + SUM_W'(eff_len));
    assign index_now  = CW'(SUM_W'(stored_reg) + SUM_W'(sif_reg));

    logic keep_c, done_c, voiced_c;
    logic [CW-1:0] index_c;

    always_comb begin
        sif_next    = sif_reg;
        peak_next   = peak_reg;
        energy_next = energy_reg;
        fcount_next = fcount_reg;
        floor_next  = floor_reg;
        vrun_next   = vrun_reg;
        qrun_next   = qrun_reg;
        trig_next   = trig_reg;
        fin_next    = fin_reg;
        stored_next = stored_reg;
        keep_c      = 1'b0;
        index_c     = '0;
        done_c      = 1'b0;
        voiced_c    = 1'b0;

        if (!fin_reg) begin
            if (end_reg) begin
                fin_next = 1'b1;
            end else if (sif_reg == '0 && limit_now) begin
                fin_next = 1'b1;
            end else begin
                if (trig_reg) begin
                    keep_c  = 1'b1;
                    index_c = index_now;
                end
                if (frame_end) begin
                    done_c = 1'b1;
                    if (!trig_reg && fcount_reg < vacg_pkg::NOISE_FRAMES) begin
                        floor_next = floor_avg;
                    end
                    voiced_c = (18'(peak_new) > floor_thr) ||
                               (energy_new >= ENERGY_W'(energy_thr));
                    if (!trig_reg) begin
                        // voiced frames push the run up, quiet ones pull it down
                        if (voiced_c) begin
                            if (vrun_reg < vacg_pkg::VOICE_TRIGGER) begin
                                vrun_next = vrun_reg + 2'd1;
                            end
                        end else if (vrun_reg != '0) begin
                            vrun_next = vrun_reg - 2'd1;
                        end
                        if (vrun_next >= vacg_pkg::VOICE_TRIGGER) begin
                            trig_next = 1'b1;
                        end
                    end else begin
                        stored_next = stored_add;
                        if (voiced_c) begin
                            qrun_next = '0;
                        end else begin
                            if (qrun_reg < vacg_pkg::QUIET_MAX) begin
                                qrun_next = qrun_reg + 6'd1;
                            end
                            if (qrun_next >= vacg_pkg::QUIET_STOP &&
                                stored_add > CW'(cfg.stop_min)) begin
                                fin_next = 1'b1;
                            end
                        end
                    end
                    if (fcount_reg < vacg_pkg::FRAME_CNT_MAX) begin
                        fcount_next = fcount_reg + 10'd1;
                    end
                    sif_next    = '0;
                    peak_next   = '0;
                    energy_next = '0;
                    if (limit_after) begin
                        fin_next = 1'b1;
                    end
                end else begin
                    sif_next    = sif_reg + SIF_W'(1);
                    peak_next   = peak_new;
                    energy_next = energy_new;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sif_reg    <= '0;
            peak_reg   <= '0;
            energy_reg <= '0;
            fcount_reg <= '0;
            floor_reg  <= '0;
            vrun_reg   <= '0;
            qrun_reg   <= '0;
            trig_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            stored_reg <= '0;
        end else if (advance) begin
            sif_reg    <= sif_next;
            peak_reg   <= peak_next;
            energy_reg <= energy_next;
            fcount_reg <= fcount_next;
            floor_reg  <= floor_next;
            vrun_reg   <= vrun_next;
            qrun_reg   <= qrun_next;
            trig_reg   <= trig_next;
            fin_reg    <= fin_next;
            stored_reg <= stored_next;
        end
    end

    // ---------------- result register ----------------
    localparam int M_TDATA_W_L = vacg_pkg::M_TDATA_W;
    logic                     out_valid_reg;
    logic                     keep_reg;
    logic                     done_reg;
    logic [M_TDATA_W_L-1:0]   tdata_reg;
    logic                     speech_c;

    assign speech_c = fin_next && trig_next && (stored_next >= CW'(cfg.speech_min));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            keep_reg  <= keep_c;
            done_reg  <= done_c;
            tdata_reg <= {6'b0, stored_next, speech_c, fin_next, trig_next, voiced_c, index_c};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = keep_reg;
    assign m_tlast  = done_reg;

endmodule

>>> design/vacg_cfg_regs.sv
module vacg_cfg_regs #(
    parameter int MAX_FRAME_LEN = vacg_pkg::DEFAULT_MAX_FRAME_LEN,
    parameter int LEN_W         = $clog2(MAX_FRAME_LEN + 1),
    parameter int THR_W         = 20 + LEN_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [vacg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vacg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output vacg_pkg::cfg_t                  cfg,
    output logic [LEN_W-1:0]                eff_len,
    output logic [THR_W-1:0]                energy_thr
);

    logic [vacg_pkg::FRAME_LENGTH_W-1:0] frame_length_reg;
    vacg_pkg::cfg_t                      cfg_reg;
    logic [THR_W-1:0]                    energy_thr_reg;
    logic [THR_W-1:0]                    energy_thr_next;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg       <= vacg_pkg::RST_FRAME_LENGTH;
            cfg_reg.frame_limit    <= vacg_pkg::RST_FRAME_LIMIT;
            cfg_reg.store_capacity <= vacg_pkg::RST_STORE_CAPACITY;
            cfg_reg.stop_min       <= vacg_pkg::RST_STOP_MIN;
            cfg_reg.speech_min     <= vacg_pkg::RST_SPEECH_MIN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                vacg_pkg::REG_FRAME_LENGTH:
                    frame_length_reg <= cfg_wdata[vacg_pkg::FRAME_LENGTH_W-1:0];
                vacg_pkg::REG_FRAME_LIMIT:
                    cfg_reg.frame_limit <= cfg_wdata[vacg_pkg::FRAME_LIMIT_W-1:0];
                vacg_pkg::REG_STORE_CAPACITY:
                    cfg_reg.store_capacity <= cfg_wdata[vacg_pkg::STORE_CAPACITY_W-1:0];
                vacg_pkg::REG_STOP_MIN:
                    cfg_reg.stop_min <= cfg_wdata[vacg_pkg::STOP_MIN_W-1:0];
                vacg_pkg::REG_SPEECH_MIN:
                    cfg_reg.speech_min <= cfg_wdata[vacg_pkg::SPEECH_MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame length clamped to [1, MAX_FRAME_LEN]
    always_comb begin
        if (frame_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(frame_length_reg) > 32'(MAX_FRAME_LEN)) begin
            eff_len = LEN_W'(MAX_FRAME_LEN);
        end else begin
            eff_len = LEN_W'(frame_length_reg);
        end
    end

    // Mean energy limit times frame length, kept registered off the sample path
    assign energy_thr_next = THR_W'(vacg_pkg::ENERGY_LIMIT) * THR_W'(eff_len);

    always_ff @(posedge aclk) begin
        energy_thr_reg <= energy_thr_next;
    end

    assign cfg        = cfg_reg;
    assign energy_thr = energy_thr_reg;

endmodule
